### rtl/core/wpa_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the windowed peak autoscale block
// no dependencies; imported by every other file of the block

package wpa_pkg;

    // window and field widths
    localparam int DEPTH      = 60;
    localparam int CNT_W      = $clog2(DEPTH);
    localparam int SAMPLE_W   = 32;
    localparam int SCALE_W    = 33;
    localparam int WEIGHT_W   = 17;
    localparam int HEAD_W     = 18;
    localparam int MIN_W      = 32;
    localparam int FRAC       = 16;
    localparam int PROD_W     = SCALE_W + HEAD_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // q16 unity and register reset values
    localparam logic [WEIGHT_W-1:0] Q16_ONE        = WEIGHT_W'(65536);
    localparam logic [WEIGHT_W-1:0] WEIGHT_RST     = WEIGHT_W'(655);
    localparam logic [HEAD_W-1:0]   HEADROOM_RST   = HEAD_W'(72090);
    localparam logic [MIN_W-1:0]    MIN_SCALE_RST  = MIN_W'(1024);

    // input opcodes
    localparam logic OP_PUSH  = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DECAY_WEIGHT = 2'd0,
        CFG_HEADROOM     = 2'd1,
        CFG_MIN_SCALE    = 2'd2
    } t_cfg_idx;

    // top level sequencer
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_MATH,
        ST_DONE
    } t_state;

    // scale arithmetic steps
    typedef enum logic [2:0] {
        SC_IDLE,
        SC_MUL_KEEP,
        SC_MUL_ADD,
        SC_MUL_HEAD,
        SC_FINISH
    } t_scale_step;

    // controls for the cell chain
    typedef struct packed {
        logic clear;
        logic push;
        logic rotate;
    } t_chain_ctl;

endpackage

### rtl/core/wpa_if.sv
`timescale 1ns / 1ps
// valid/ready channel interfaces for sample input, result output and config writes
// depends on wpa_pkg for field widths

interface wpa_in_if import wpa_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                opcode;
    logic [SAMPLE_W-1:0] sample;

    modport source (output valid, output opcode, output sample, input ready);
    modport sink   (input valid, input opcode, input sample, output ready);
endinterface

interface wpa_out_if import wpa_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [SCALE_W-1:0]  scale;
    logic [SAMPLE_W-1:0] window_max;

    modport source (output valid, output scale, output window_max, input ready);
    modport sink   (input valid, input scale, input window_max, output ready);
endinterface

interface wpa_cfg_if import wpa_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/core/windowed_peak_autoscale.sv
`timescale 1ns / 1ps
// top level of the windowed peak autoscale block
// depends on wpa_pkg, wpa_if, wpa_chain and wpa_scale

// A push beat enters a ring of DEPTH cells, the ring then rotates once past a single
// comparator to find the window maximum, one shared multiplier then forms the decay
// blend and headroom floor in the keep, add and head steps followed by a finish
// step, and the done state moves the result into the output register. A clear beat
// zeroes every cell at once and its result goes from the result registers into the
// output register in the done state. The next beat is taken in the cycle after the
// previous result enters the output register, so no beat is taken while one is still
// in progress; a result left waiting in the output register holds the next one back.
// Configuration writes are always taken and belong between beats.

module windowed_peak_autoscale import wpa_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    wpa_in_if.sink    i_in,
    wpa_out_if.source o_out,
    wpa_cfg_if.sink   i_cfg
);

    t_state              r_state, n_state;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic [SCALE_W-1:0]  r_held, n_held;
    logic [SCALE_W-1:0]  r_res_scale, n_res_scale;
    logic [SAMPLE_W-1:0] r_res_max, n_res_max;
    logic                r_out_valid, n_out_valid;
    logic [SCALE_W-1:0]  r_out_scale, n_out_scale;
    logic [SAMPLE_W-1:0] r_out_max, n_out_max;
    logic [WEIGHT_W-1:0] r_weight;
    logic [HEAD_W-1:0]   r_headroom;
    logic [MIN_W-1:0]    r_min_scale;
    t_chain_ctl          w_ctl;
    logic                w_start;
    logic                w_done;
    logic [SCALE_W-1:0]  w_scale;
    logic [SAMPLE_W-1:0] w_max;
    logic                w_in_beat;

    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DEPTH - 1);

    assign i_in.ready  = (r_state == ST_IDLE);
    assign w_in_beat   = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_weight    <= WEIGHT_RST;
            r_headroom  <= HEADROOM_RST;
            r_min_scale <= MIN_SCALE_RST;
        end else if (i_cfg.valid) begin
            case (t_cfg_idx'(i_cfg.index))
                CFG_DECAY_WEIGHT: r_weight    <= i_cfg.data[WEIGHT_W-1:0];
                CFG_HEADROOM:     r_headroom  <= i_cfg.data[HEAD_W-1:0];
                CFG_MIN_SCALE:    r_min_scale <= i_cfg.data[MIN_W-1:0];
                default: ;
            endcase
        end
    end

    wpa_chain u_chain (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_ctl),
        .i_sample (i_in.sample),
        .o_max    (w_max)
    );

    wpa_scale u_scale (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_start),
        .i_held      (r_held),
        .i_max       (w_max),
        .i_weight    (r_weight),
        .i_headroom  (r_headroom),
        .i_min_scale (r_min_scale),
        .o_done      (w_done),
        .o_scale     (w_scale)
    );

    // sequencer: next state, chain controls and result capture
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_held      = r_held;
        n_res_scale = r_res_scale;
        n_res_max   = r_res_max;
        n_out_valid = r_out_valid;
        n_out_scale = r_out_scale;
        n_out_max   = r_out_max;
        w_ctl       = '0;
        w_start     = 1'b0;

        // output beat taken
        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (w_in_beat) begin
                    if (i_in.opcode == OP_CLEAR) begin
                        w_ctl.clear = 1'b1;
                        n_held      = SCALE_W'(r_min_scale);
                        n_res_scale = SCALE_W'(r_min_scale);
                        n_res_max   = '0;
                        n_state     = ST_DONE;
                    end else begin
                        w_ctl.push = 1'b1;
                        n_cnt      = '0;
                        n_state    = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                w_ctl.rotate = 1'b1;
                n_cnt        = r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    w_start = 1'b1;
                    n_state = ST_MATH;
                end
            end
            ST_MATH: begin
                if (w_done) begin
                    n_held      = w_scale;
                    n_res_scale = w_scale;
                    n_res_max   = w_max;
                    n_state     = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid = 1'b1;
                    n_out_scale = r_res_scale;
                    n_out_max   = r_res_max;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_held      <= SCALE_W'(MIN_SCALE_RST);
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_held      <= n_held;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_res_scale <= n_res_scale;
        r_res_max   <= n_res_max;
        r_out_scale <= n_out_scale;
        r_out_max   <= n_out_max;
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.scale      = r_out_scale;
    assign o_out.window_max = r_out_max;

endmodule

### rtl/core/wpa_cell.sv
`timescale 1ns / 1ps
// one history cell: holds a sample and takes its neighbor's on each shift
// depends on wpa_pkg

module wpa_cell import wpa_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_chain_ctl          i_ctl,
    input  logic [SAMPLE_W-1:0] i_d,
    output logic [SAMPLE_W-1:0] o_q
);

    logic [SAMPLE_W-1:0] r_q;

    // clear to zero, load neighbor on push or rotate
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            r_q <= '0;
        end else if (i_ctl.push || i_ctl.rotate) begin
            r_q <= i_d;
        end
    end

    assign o_q = r_q;

endmodule

### rtl/core/wpa_chain.sv
`timescale 1ns / 1ps
// ring of history cells with a single running-max comparator at the tail
// depends on wpa_pkg and wpa_cell

module wpa_chain import wpa_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_chain_ctl          i_ctl,
    input  logic [SAMPLE_W-1:0] i_sample,
    output logic [SAMPLE_W-1:0] o_max
);

    logic [SAMPLE_W-1:0] w_q [DEPTH];
    logic [SAMPLE_W-1:0] w_d [DEPTH];
    logic [SAMPLE_W-1:0] r_max;
    logic [SAMPLE_W-1:0] w_tail;

    assign w_tail = w_q[DEPTH-1];

    // head takes the new sample on push, the tail on rotate
    assign w_d[0] = i_ctl.push ? i_sample : w_tail;

    genvar g;
    generate
        for (g = 1; g < DEPTH; g++) begin : g_link
            assign w_d[g] = w_q[g-1];
        end
        for (g = 0; g < DEPTH; g++) begin : g_cell
            wpa_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctl   (i_ctl),
                .i_d     (w_d[g]),
                .o_q     (w_q[g])
            );
        end
    endgenerate

    // running max over the tail as the ring rotates once
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear || i_ctl.push) begin
            r_max <= '0;
        end else if (i_ctl.rotate && (w_tail > r_max)) begin
            r_max <= w_tail;
        end
    end

    assign o_max = r_max;

endmodule

### rtl/core/wpa_scale.sv
`timescale 1ns / 1ps
// scale update: jump, q16 decay blend, headroom floor and min floor
// one shared multiplier over three steps; depends on wpa_pkg

module wpa_scale import wpa_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [SCALE_W-1:0]  i_held,
    input  logic [SAMPLE_W-1:0] i_max,
    input  logic [WEIGHT_W-1:0] i_weight,
    input  logic [HEAD_W-1:0]   i_headroom,
    input  logic [MIN_W-1:0]    i_min_scale,
    output logic                o_done,
    output logic [SCALE_W-1:0]  o_scale
);

    t_scale_step         r_step, n_step;
    logic [PROD_W-1:0]   r_prod, n_prod;
    logic [PROD_W-1:0]   r_acc, n_acc;
    logic [WEIGHT_W-1:0] w_weight;
    logic [WEIGHT_W-1:0] w_keep;
    logic [SCALE_W-1:0]  m_a;
    logic [HEAD_W-1:0]   m_b;
    logic [PROD_W-1:0]   m_p;
    logic [SCALE_W-1:0]  w_max_ext;
    logic [SCALE_W-1:0]  w_blend;
    logic [SCALE_W-1:0]  w_floor;
    logic [SCALE_W-1:0]  w_min_ext;
    logic [SCALE_W-1:0]  w_pick;

    // weight above one counts as one
    assign w_weight  = (i_weight > Q16_ONE) ? Q16_ONE : i_weight;
    assign w_keep    = Q16_ONE - w_weight;
    assign w_max_ext = SCALE_W'(i_max);
    assign w_min_ext = SCALE_W'(i_min_scale);

    // shared multiplier operands
    always_comb begin
        case (r_step)
            SC_MUL_KEEP: begin
                m_a = i_held;
                m_b = HEAD_W'(w_keep);
            end
            SC_MUL_ADD: begin
                m_a = w_max_ext;
                m_b = HEAD_W'(w_weight);
            end
            SC_MUL_HEAD: begin
                m_a = w_max_ext;
                m_b = i_headroom;
            end
            default: begin
                m_a = '0;
                m_b = '0;
            end
        endcase
    end

    assign m_p = PROD_W'(m_a) * PROD_W'(m_b);

    // blend truncated, headroom product saturated to 33 bits
    assign w_blend = r_acc[FRAC+SCALE_W-1:FRAC];
    assign w_floor = r_prod[FRAC+SCALE_W] ? {SCALE_W{1'b1}} : r_prod[FRAC+SCALE_W-1:FRAC];

    // final selection
    always_comb begin
        if (w_max_ext > i_held) begin
            w_pick = w_max_ext;
        end else if (w_blend < w_floor) begin
            w_pick = w_floor;
        end else begin
            w_pick = w_blend;
        end
        o_scale = (w_pick < w_min_ext) ? w_min_ext : w_pick;
    end

    // step sequencing
    always_comb begin
        n_step = r_step;
        n_prod = r_prod;
        n_acc  = r_acc;
        o_done = 1'b0;
        case (r_step)
            SC_IDLE: begin
                if (i_start) begin
                    n_step = SC_MUL_KEEP;
                end
            end
            SC_MUL_KEEP: begin
                n_prod = m_p;
                n_step = SC_MUL_ADD;
            end
            SC_MUL_ADD: begin
                n_acc  = r_prod;
                n_prod = m_p;
                n_step = SC_MUL_HEAD;
            end
            SC_MUL_HEAD: begin
                n_acc  = r_acc + r_prod;
                n_prod = m_p;
                n_step = SC_FINISH;
            end
            SC_FINISH: begin
                o_done = 1'b1;
                n_step = SC_IDLE;
            end
            default: begin
                n_step = SC_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= SC_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
        r_acc  <= n_acc;
    end

endmodule
